FILE: rtl/fcr_pkg.sv
// Shared widths, types, command codes and the reset order list of the FIFO replacement block.
package fcr_pkg;

    // Geometry of the replacement state.
    localparam int SET_COUNT = 64;
    localparam int ASSOC     = 8;

    // Widths of the channel fields, fixed by the interface.
    localparam int CMD_W    = 1;
    localparam int SET_IN_W = 6;
    localparam int WAY_IN_W = 3;
    localparam int VICTIM_W = 3;

    // Derived internal widths.
    localparam int WAY_W  = $clog2(ASSOC);
    localparam int SET_W  = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
    localparam int LIST_W = ASSOC * WAY_W;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_QUERY = 1'b0;
    localparam logic [CMD_W-1:0] CMD_EVICT = 1'b1;

    typedef logic [WAY_W-1:0]  t_way;
    typedef logic [SET_W-1:0]  t_set_addr;
    typedef logic [LIST_W-1:0] t_list;

    // Read request into the list memory.
    typedef struct packed {
        logic      en;
        t_set_addr addr;
    } t_mem_rd;

    // Write request into the list memory.
    typedef struct packed {
        logic      en;
        t_set_addr addr;
        t_list     data;
    } t_mem_wr;

    // Order list after reset: ways in ascending order, way 0 at the front (lowest slot).
    function automatic t_list reset_list();
        t_list l;
        l = '0;
        for (int i = 0; i < ASSOC; i++) begin
            l[i*WAY_W +: WAY_W] = WAY_W'(i);
        end
        return l;
    endfunction

    // Memory address taken from the set field of an input item.
    function automatic t_set_addr set_addr(input logic [SET_IN_W-1:0] s);
        return SET_W'(s);
    endfunction

endpackage

FILE: rtl/fcr_in_if.sv
// Input channel carrying query and eviction items.
interface fcr_in_if;
    logic                         valid;
    logic                         ready;
    logic [fcr_pkg::CMD_W-1:0]    command;
    logic [fcr_pkg::SET_IN_W-1:0] set_index;
    logic [fcr_pkg::WAY_IN_W-1:0] way;

    modport source (output valid, command, set_index, way, input ready);
    modport sink   (input valid, command, set_index, way, output ready);
endinterface

FILE: rtl/fcr_out_if.sv
// Output channel carrying the next victim way.
interface fcr_out_if;
    logic                         valid;
    logic                         ready;
    logic [fcr_pkg::VICTIM_W-1:0] victim_way;

    modport source (output valid, victim_way, input ready);
    modport sink   (input valid, victim_way, output ready);
endinterface

FILE: rtl/fcr_list_mem.sv
// Order list memory, one entry per set, with per-set valid bits standing in for the reset contents.
module fcr_list_mem (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  fcr_pkg::t_mem_rd i_rd,
    input  fcr_pkg::t_mem_wr i_wr,
    output fcr_pkg::t_list   o_rd_data
);

    fcr_pkg::t_list                r_mem [fcr_pkg::SET_COUNT];
    logic [fcr_pkg::SET_COUNT-1:0] r_vld;
    fcr_pkg::t_list                r_rd_data;
    logic                          r_rd_vld;

    // A set becomes valid on its first write; reset returns every set to the ascending order.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    // Synchronous write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
            r_rd_vld  <= r_vld[i_rd.addr];
        end
    end

    // An entry never written reads as the reset order.
    assign o_rd_data = r_rd_vld ? r_rd_data : fcr_pkg::reset_list();

endmodule

FILE: rtl/fcr_reorder.sv
// Moves one way of an order list to the back and reports the new front.
module fcr_reorder (
    input  logic                         i_en,
    input  fcr_pkg::t_list               i_list,
    input  fcr_pkg::t_way                i_way,
    output fcr_pkg::t_list               o_list,
    output logic [fcr_pkg::VICTIM_W-1:0] o_front
);

    logic [fcr_pkg::ASSOC-1:0] match;
    logic [fcr_pkg::ASSOC-1:0] seen;

    // Locate the way and mark every slot from its place to the back.
    always_comb begin
        for (int i = 0; i < fcr_pkg::ASSOC; i++) begin
            match[i] = i_en && (i_list[i*fcr_pkg::WAY_W +: fcr_pkg::WAY_W] == i_way);
        end
        seen[0] = match[0];
        for (int i = 1; i < fcr_pkg::ASSOC; i++) begin
            seen[i] = seen[i-1] | match[i];
        end
    end

    // Slots at or behind the way shift one place forward; the way itself goes to the back.
    always_comb begin
        for (int i = 0; i < fcr_pkg::ASSOC - 1; i++) begin
            o_list[i*fcr_pkg::WAY_W +: fcr_pkg::WAY_W] = seen[i]
                ? i_list[(i+1)*fcr_pkg::WAY_W +: fcr_pkg::WAY_W]
                : i_list[i*fcr_pkg::WAY_W +: fcr_pkg::WAY_W];
        end
        o_list[(fcr_pkg::ASSOC-1)*fcr_pkg::WAY_W +: fcr_pkg::WAY_W] = seen[fcr_pkg::ASSOC-1]
            ? i_way
            : i_list[(fcr_pkg::ASSOC-1)*fcr_pkg::WAY_W +: fcr_pkg::WAY_W];
    end

    // The front is the low slot, narrowed or widened to the result field.
    assign o_front = fcr_pkg::VICTIM_W'(o_list[fcr_pkg::WAY_W-1:0]);

endmodule

FILE: rtl/fifo_cache_replacement_top.sv
// Top level of the FIFO cache replacement block: read stage, reorder, write-back and result register.
//
//  Port    Dir  Payload                          Transfer
//  i_in    in   command, set_index, way          valid && ready
//  o_out   out  victim_way                       valid && ready
//
//  Per item, the set's list is read from the list memory, then reordered, written back
//  on an eviction, and the result register is loaded. The read stage holds one item;
//  the next is accepted only once the last has left. Reset clears the per-set valid
//  bits with no clearing pass. A result waiting in the output register does not block the
//  next transfer, which is read and then held in the read stage until the register frees.
module fifo_cache_replacement_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fcr_in_if.sink    i_in,
    fcr_out_if.source o_out
);

    logic                         r_s1_vld;
    logic [fcr_pkg::CMD_W-1:0]    r_s1_cmd;
    logic [fcr_pkg::SET_IN_W-1:0] r_s1_set;
    logic [fcr_pkg::WAY_IN_W-1:0] r_s1_way;
    logic                         r_out_vld;
    logic [fcr_pkg::VICTIM_W-1:0] r_victim;
    logic                         n_out_vld;

    logic                         accept;
    logic                         out_free;
    logic                         done;
    logic                         set_ok;
    logic                         way_ok;
    logic                         evict;
    fcr_pkg::t_mem_rd             rd_req;
    fcr_pkg::t_mem_wr             wr_req;
    fcr_pkg::t_list               rd_list;
    fcr_pkg::t_list               new_list;
    logic [fcr_pkg::VICTIM_W-1:0] front;

    // Input handshake: one item at a time in the read stage.
    assign i_in.ready = !r_s1_vld;
    assign accept     = i_in.valid && i_in.ready;

    // The item completes once the result register can take its answer.
    assign out_free = !r_out_vld || o_out.ready;
    assign done     = r_s1_vld && out_free;

    // Range checks on the set and way of the item in the read stage.
    assign set_ok = 32'(r_s1_set) < 32'(fcr_pkg::SET_COUNT);
    assign way_ok = 32'(r_s1_way) < 32'(fcr_pkg::ASSOC);
    assign evict  = (r_s1_cmd == fcr_pkg::CMD_EVICT) && way_ok;

    // Memory requests.
    assign rd_req.en   = accept;
    assign rd_req.addr = fcr_pkg::set_addr(i_in.set_index);
    assign wr_req.en   = done && set_ok && evict;
    assign wr_req.addr = fcr_pkg::set_addr(r_s1_set);
    assign wr_req.data = new_list;

    fcr_list_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd      (rd_req),
        .i_wr      (wr_req),
        .o_rd_data (rd_list)
    );

    fcr_reorder u_reorder (
        .i_en    (evict),
        .i_list  (rd_list),
        .i_way   (fcr_pkg::WAY_W'(r_s1_way)),
        .o_list  (new_list),
        .o_front (front)
    );

    // Result register holds until its transfer completes.
    always_comb begin
        n_out_vld = r_out_vld;
        if (done) begin
            n_out_vld = 1'b1;
        end else if (o_out.ready) begin
            n_out_vld = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= accept || (r_s1_vld && !done);
            r_out_vld <= n_out_vld;
        end
    end

    // Payload of the read stage and the result register.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cmd <= i_in.command;
            r_s1_set <= i_in.set_index;
            r_s1_way <= i_in.way;
        end
        if (done) begin
            r_victim <= set_ok ? front : '0;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.victim_way = r_victim;

`ifndef SYNTH
    // An accepted transfer occupies the read stage in the next cycle.
    a_accept_to_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_vld)
        else $error("accepted item missing from read stage");

    // A stalled item keeps its set and way until it completes.
    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !done) |=> (r_s1_vld && $stable(r_s1_set) && $stable(r_s1_way)))
        else $error("stalled item changed in read stage");

    // A new result appears only after an item has left the read stage.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(r_s1_vld))
        else $error("result without an item in flight");

    // The memory is never written while a read of the same set could be in flight.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_req.en |-> !rd_req.en)
        else $error("list read and write overlap");
`endif

endmodule
